@@ src/mpct_pkg.sv @@
package mpct_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned X_W     = 10;
  localparam int unsigned Y_W     = 9;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Defaults and reset values
  localparam int unsigned STRIDE_DEFAULT = 640;
  localparam logic [X_W-1:0]     POS_X_RESET        = X_W'(320);
  localparam logic [Y_W-1:0]     POS_Y_RESET        = Y_W'(240);
  localparam logic [X_W-1:0]     WIDTH_RESET        = X_W'(640);
  localparam logic [Y_W-1:0]     HEIGHT_RESET       = Y_W'(480);
  localparam logic [COLOR_W-1:0] BG_COLOR_RESET     = COLOR_W'(0);
  localparam logic [COLOR_W-1:0] CURSOR_COLOR_RESET = COLOR_W'(15);
  localparam logic [ADDR_W-1:0]  FRAME_BASE_RESET   = ADDR_W'(0);

  // Packet queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_BASE   = 3'd0,
    CFG_SCREEN_W     = 3'd1,
    CFG_SCREEN_H     = 3'd2,
    CFG_BG_COLOR     = 3'd3,
    CFG_CURSOR_COLOR = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  // Position of the next byte within a packet
  typedef enum logic [1:0] {
    FS_FLAG,
    FS_DX,
    FS_DY
  } front_state_t;

  // Movement bytes of one complete packet
  typedef struct packed {
    logic [BYTE_W-1:0] dx;
    logic [BYTE_W-1:0] dy_raw;
  } packet_t;

endpackage

@@ src/mpct_ifs.sv @@
interface mpct_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mpct_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_address;
  logic [7:0]  pixel_color;
  logic [9:0]  cursor_x;
  logic [8:0]  cursor_y;
  logic        last;

  modport source (output valid, output pixel_address, output pixel_color,
                  output cursor_x, output cursor_y, output last, input ready);
  modport sink (input valid, input pixel_address, input pixel_color,
                input cursor_x, input cursor_y, input last, output ready);
endinterface

@@ src/mpct_front.sv @@
module mpct_front
  import mpct_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  mpct_byte_if.sink         byte_in,
  input  logic              q_full,
  output logic              q_push,
  output packet_t           q_pkt
);

  front_state_t      state;
  front_state_t      state_next;
  logic [BYTE_W-1:0] dx_byte;
  logic              accept;

  // Take every byte, except the closing one when the queue has no room
  always_comb begin
    byte_in.ready = 1'b1;
    q_push        = 1'b0;
    unique case (state)
      FS_FLAG: begin
        byte_in.ready = 1'b1;
      end
      FS_DX: begin
        byte_in.ready = 1'b1;
      end
      FS_DY: begin
        byte_in.ready = !q_full;
        q_push        = byte_in.valid && !q_full;
      end
      default: begin
        byte_in.ready = 1'b1;
      end
    endcase
  end

  assign accept = byte_in.valid && byte_in.ready;

  // Advance through the three bytes of a packet
  always_comb begin
    state_next = state;
    unique case (state)
      FS_FLAG: if (accept) state_next = FS_DX;
      FS_DX:   if (accept) state_next = FS_DY;
      FS_DY:   if (accept) state_next = FS_FLAG;
      default: state_next = FS_FLAG;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_FLAG;
    end else begin
      state <= state_next;
    end
  end

  // Hold the X movement byte; the flag byte is dropped
  always_ff @(posedge clk) begin
    if (accept && state == FS_DX) begin
      dx_byte <= byte_in.rx_byte;
    end
  end

  assign q_pkt.dx     = dx_byte;
  assign q_pkt.dy_raw = byte_in.rx_byte;

endmodule

@@ src/mpct_queue.sv @@
module mpct_queue
  import mpct_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  packet_t push_pkt,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output packet_t head
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  packet_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Store a packet at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_pkt;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("packet pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("packet popped from an empty queue");
`endif

endmodule

@@ src/mpct_back.sv @@
module mpct_back
  import mpct_pkg::*;
#(
  parameter int unsigned LINE_STRIDE = STRIDE_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_wr_t    cfg,
  input  logic       q_not_empty,
  input  packet_t    q_head,
  output logic       q_pop,
  mpct_pix_if.source pix_out
);

  localparam int unsigned STRIDE_W = $clog2(LINE_STRIDE + 1);
  localparam int unsigned ROW_W    = STRIDE_W + Y_W;

  // Configuration
  logic [ADDR_W-1:0]  frame_base;
  logic [X_W-1:0]     screen_width;
  logic [Y_W-1:0]     screen_height;
  logic [COLOR_W-1:0] background_color;
  logic [COLOR_W-1:0] cursor_color;

  // Cursor and output register
  logic [X_W-1:0]     pos_x;
  logic [Y_W-1:0]     pos_y;
  logic               draw_pending;
  logic               out_valid;
  logic [ADDR_W-1:0]  out_address;
  logic [COLOR_W-1:0] out_color;
  logic [X_W-1:0]     out_x;
  logic [Y_W-1:0]     out_y;
  logic               out_last;

  logic               load_ok;
  logic [BYTE_W-1:0]  dy_byte;
  logic signed [X_W+1:0] sum_x;
  logic signed [Y_W+1:0] sum_y;
  logic [X_W-1:0]     top_x;
  logic [Y_W-1:0]     top_y;
  logic [X_W-1:0]     new_x;
  logic [Y_W-1:0]     new_y;
  logic [ROW_W-1:0]   row_off;
  logic [ADDR_W-1:0]  cur_address;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_base       <= FRAME_BASE_RESET;
      screen_width     <= WIDTH_RESET;
      screen_height    <= HEIGHT_RESET;
      background_color <= BG_COLOR_RESET;
      cursor_color     <= CURSOR_COLOR_RESET;
    end else if (cfg.we) begin
      unique case (cfg.index)
        CFG_FRAME_BASE:   frame_base       <= cfg.data[ADDR_W-1:0];
        CFG_SCREEN_W:     screen_width     <= cfg.data[X_W-1:0];
        CFG_SCREEN_H:     screen_height    <= cfg.data[Y_W-1:0];
        CFG_BG_COLOR:     background_color <= cfg.data[COLOR_W-1:0];
        CFG_CURSOR_COLOR: cursor_color     <= cfg.data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Move the cursor: X gains dx, Y gains the negated Y byte, both signed
  assign dy_byte = BYTE_W'(~q_head.dy_raw + 1'b1);
  assign sum_x = $signed({2'b00, pos_x})
               + $signed({{(X_W+2-BYTE_W){q_head.dx[BYTE_W-1]}}, q_head.dx});
  assign sum_y = $signed({2'b00, pos_y})
               + $signed({{(Y_W+2-BYTE_W){dy_byte[BYTE_W-1]}}, dy_byte});

  // A zero screen size behaves as one
  assign top_x = (screen_width == '0) ? '0 : screen_width - 1'b1;
  assign top_y = (screen_height == '0) ? '0 : screen_height - 1'b1;

  always_comb begin
    if (sum_x[X_W+1]) begin
      new_x = '0;
    end else if (sum_x[X_W:0] > {1'b0, top_x}) begin
      new_x = top_x;
    end else begin
      new_x = sum_x[X_W-1:0];
    end
    if (sum_y[Y_W+1]) begin
      new_y = '0;
    end else if (sum_y[Y_W:0] > {1'b0, top_y}) begin
      new_y = top_y;
    end else begin
      new_y = sum_y[Y_W-1:0];
    end
  end

  // Address of the current cursor position; serves both writes
  assign row_off     = ROW_W'(pos_y) * ROW_W'(LINE_STRIDE);
  assign cur_address = frame_base + ADDR_W'(pos_x) + ADDR_W'(row_off);

  assign load_ok = !out_valid || pix_out.ready;
  assign q_pop   = load_ok && !draw_pending && q_not_empty;

  // Erase write first, then the draw write from the updated position
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      draw_pending <= 1'b0;
      pos_x        <= POS_X_RESET;
      pos_y        <= POS_Y_RESET;
    end else if (load_ok) begin
      if (draw_pending) begin
        out_valid    <= 1'b1;
        draw_pending <= 1'b0;
      end else if (q_not_empty) begin
        out_valid    <= 1'b1;
        draw_pending <= 1'b1;
        pos_x        <= new_x;
        pos_y        <= new_y;
      end else begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      out_address <= cur_address;
      if (draw_pending) begin
        out_color <= cursor_color;
        out_x     <= pos_x;
        out_y     <= pos_y;
        out_last  <= 1'b1;
      end else begin
        out_color <= background_color;
        out_x     <= new_x;
        out_y     <= new_y;
        out_last  <= 1'b0;
      end
    end
  end

  assign pix_out.valid         = out_valid;
  assign pix_out.pixel_address = out_address;
  assign pix_out.pixel_color   = out_color;
  assign pix_out.cursor_x      = out_x;
  assign pix_out.cursor_y      = out_y;
  assign pix_out.last          = out_last;

`ifndef NO_ASSERTIONS
  a_pending_has_erase: assert property (@(posedge clk) disable iff (rst)
    draw_pending |-> (out_valid && !out_last))
    else $error("draw write pending without an erase write on the output");

  a_draw_follows_erase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pix_out.ready && !out_last) |=> (out_valid && out_last))
    else $error("erase write not followed by its draw write");
`endif

endmodule

@@ src/mouse_packet_cursor_tracker_unit.sv @@
// Mouse packet cursor tracker. Groups received bytes into three-byte packets
// (flag, X movement, Y movement) and, on each completed packet, moves the
// cursor and emits two pixel writes: the old position in the background colour
// (last low), then the new, clamped position in the cursor colour (last high).
// Addresses are frame_base + x + y * LINE_STRIDE, modulo 2^32. A finished
// packet is queued (two packets deep) and the back end issues its two writes,
// erase then draw, through a registered output, so the block sustains one
// byte per cycle while the pixel sink keeps up. Registers are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block is
// idle (not enforced by the block). Indexes beyond the list are ignored.
module mouse_packet_cursor_tracker_unit
  import mpct_pkg::*;
#(
  parameter int unsigned LINE_STRIDE = STRIDE_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  mpct_byte_if.sink            byte_in,
  mpct_pix_if.source           pix_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_wr_t cfg;
  logic    q_full;
  logic    q_push;
  packet_t q_pkt;
  logic    q_pop;
  logic    q_not_empty;
  packet_t q_head;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  mpct_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_pkt   (q_pkt)
  );

  mpct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_pkt  (q_pkt),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  mpct_back #(
    .LINE_STRIDE (LINE_STRIDE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .pix_out     (pix_out)
  );

endmodule

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpct_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned TAIL         = 20;
  localparam int unsigned RAND_PHASES  = 10;
  localparam int unsigned PHASE_PKTS   = 45;
  localparam int unsigned REPORT_LIMIT = 50;

  // One pixel write as the block emits it
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic [X_W-1:0]     x;
    logic [Y_W-1:0]     y;
    logic               last;
  } pix_write_t;

  // Cursor tracker predictor with the queue of pixel writes still owed
  class cursor_board;
    pix_write_t         pending[$];
    logic [ADDR_W-1:0]  frame_base;
    logic [X_W-1:0]     width;
    logic [Y_W-1:0]     height;
    logic [COLOR_W-1:0] bg_color;
    logic [COLOR_W-1:0] cur_color;
    logic [1:0]         byte_pos;
    logic [BYTE_W-1:0]  dx_byte;
    logic [X_W-1:0]     pos_x;
    logic [Y_W-1:0]     pos_y;
    int unsigned        bytes_taken;
    int unsigned        packets;
    int unsigned        writes_checked;
    int unsigned        mismatches;

    function new();
      frame_base = FRAME_BASE_RESET;
      width      = WIDTH_RESET;
      height     = HEIGHT_RESET;
      bg_color   = BG_COLOR_RESET;
      cur_color  = CURSOR_COLOR_RESET;
      byte_pos   = 2'd0;
      dx_byte    = '0;
      pos_x      = POS_X_RESET;
      pos_y      = POS_Y_RESET;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_FRAME_BASE:   frame_base = data;
        CFG_SCREEN_W:     width      = data[X_W-1:0];
        CFG_SCREEN_H:     height     = data[Y_W-1:0];
        CFG_BG_COLOR:     bg_color   = data[COLOR_W-1:0];
        CFG_CURSOR_COLOR: cur_color  = data[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    // Clamp to 0 .. size-1, a zero size behaving as one
    function int fit_axis(int v, int size);
      int top;
      top = (size == 0) ? 0 : size - 1;
      if (v < 0) return 0;
      if (v > top) return top;
      return v;
    endfunction

    function logic [ADDR_W-1:0] pixel_at(logic [X_W-1:0] x, logic [Y_W-1:0] y);
      return frame_base + ADDR_W'(x) + ADDR_W'(y) * ADDR_W'(STRIDE_DEFAULT);
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] neg;
      int                dx;
      int                dy;
      int                nx;
      int                ny;
      pix_write_t        w;
      bytes_taken++;
      case (byte_pos)
        2'd0: byte_pos = 2'd1;
        2'd1: begin
          dx_byte  = b;
          byte_pos = 2'd2;
        end
        default: begin
          byte_pos = 2'd0;
          packets++;
          neg = BYTE_W'(0) - b;
          dx  = int'($signed(dx_byte));
          dy  = int'($signed(neg));
          nx  = fit_axis(int'(pos_x) + dx, int'(width));
          ny  = fit_axis(int'(pos_y) + dy, int'(height));
          // erase at the old spot, then paint the new one
          w = '{pixel_at(pos_x, pos_y), bg_color, X_W'(nx), Y_W'(ny), 1'b0};
          pending.push_back(w);
          pos_x = X_W'(nx);
          pos_y = Y_W'(ny);
          w = '{pixel_at(pos_x, pos_y), cur_color, pos_x, pos_y, 1'b1};
          pending.push_back(w);
        end
      endcase
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t ns: write %0d %s expected %0h actual %0h",
                   $time, writes_checked, name, want, got);
      end
    endfunction

    function void check_write(pix_write_t got);
      pix_write_t want;
      writes_checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t ns: unexpected write expected none actual addr %0h colour %0h",
                   $time, got.addr, got.color);
        return;
      end
      want = pending.pop_front();
      compare_field("pixel_address", want.addr, got.addr);
      compare_field("pixel_color", want.color, got.color);
      compare_field("cursor_x", want.x, got.x);
      compare_field("cursor_y", want.y, got.y);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  mpct_byte_if byte_ch ();
  mpct_pix_if  pix_ch ();

  cursor_board board = new();

  int unsigned burst_left;
  bit          steady;
  int unsigned screens;
  int unsigned idle_cycles;

  mouse_packet_cursor_tracker_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_ch),
    .pix_out   (pix_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Receiver stall pattern, its mode taken from the top bits of a free-running counter
  initial begin
    logic [10:0] rcnt;
    rcnt = '0;
    pix_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rcnt = rcnt + 1'b1;
      case (rcnt[10:8])
        3'd0, 3'd1: pix_ch.ready <= 1'b1;
        3'd2:       pix_ch.ready <= ($urandom_range(0, 3) != 0);
        3'd3:       pix_ch.ready <= rcnt[0];
        3'd4:       pix_ch.ready <= ($urandom_range(0, 2) == 0);
        3'd5:       pix_ch.ready <= (rcnt[3:0] < 4'd12);
        3'd6:       pix_ch.ready <= (rcnt[5:0] >= 6'd20);
        default:    pix_ch.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Note accepted items, register writes and pixel writes
  always @(posedge clk) begin : monitor
    pix_write_t got;
    if (!rst) begin
      if (cfg_we)
        board.write_reg(cfg_reg_e'(cfg_index), cfg_data);
      if (pix_ch.valid && pix_ch.ready) begin
        got.addr  = pix_ch.pixel_address;
        got.color = pix_ch.pixel_color;
        got.x     = pix_ch.cursor_x;
        got.y     = pix_ch.cursor_y;
        got.last  = pix_ch.last;
        board.check_write(got);
      end
      if (byte_ch.valid && byte_ch.ready)
        board.take_byte(byte_ch.rx_byte);
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (byte_ch.valid && byte_ch.ready) || (pix_ch.valid && pix_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Hold one byte on the channel until it is taken
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
  endtask

  // Send in bursts with random gaps in between
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_byte(b);
  endtask

  task automatic send_packet(input logic [BYTE_W-1:0] flags, input logic [BYTE_W-1:0] dx,
                             input logic [BYTE_W-1:0] dy);
    push_byte(flags);
    push_byte(dx);
    push_byte(dy);
  endtask

  // Stop sending and wait for every owed write, then let the block settle
  task automatic hold_until_drained();
    byte_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_screen(input logic [ADDR_W-1:0] base, input int unsigned w,
                            input int unsigned h, input logic [COLOR_W-1:0] bg,
                            input logic [COLOR_W-1:0] cur);
    hold_until_drained();
    write_reg(CFG_FRAME_BASE, base);
    write_reg(CFG_SCREEN_W, CFG_W'(w));
    write_reg(CFG_SCREEN_H, CFG_W'(h));
    write_reg(CFG_BG_COLOR, CFG_W'(bg));
    write_reg(CFG_CURSOR_COLOR, CFG_W'(cur));
    cfg_we <= 1'b0;
    screens++;
  endtask

  // Movement byte: a quarter small steps, a quarter extremes, the rest any value
  function automatic logic [BYTE_W-1:0] pick_delta();
    logic [BYTE_W-1:0] edges [6];
    edges = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h01, 8'h81};
    case ($urandom_range(0, 3))
      0:       return BYTE_W'(int'($urandom_range(0, 16)) - 8);
      1:       return edges[$urandom_range(0, 5)];
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_screen();
    logic [ADDR_W-1:0]  base;
    int unsigned        w;
    int unsigned        h;
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] cur;
    case ($urandom_range(0, 3))
      0:       base = '0;
      1:       base = 32'hFFFF_FFFF - ADDR_W'($urandom_range(0, 1000));
      default: base = $urandom();
    endcase
    case ($urandom_range(0, 5))
      0: begin w = 640; h = 480; end
      1: begin w = 1; h = 1; end
      2: begin w = $urandom_range(1, 16); h = $urandom_range(1, 16); end
      3: begin w = 640; h = $urandom_range(1, 480); end
      default: begin w = $urandom_range(1, 640); h = $urandom_range(1, 480); end
    endcase
    bg  = $urandom_range(0, 1) ? COLOR_W'($urandom_range(0, 255)) : 8'h00;
    cur = $urandom_range(0, 1) ? COLOR_W'($urandom_range(0, 255)) : 8'hFF;
    set_screen(base, w, h, bg, cur);
  endtask

  initial begin
    int unsigned phase;
    int unsigned i;
    rst             <= 1'b1;
    byte_ch.valid   <= 1'b0;
    byte_ch.rx_byte <= '0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_FRAME_BASE;
    cfg_data        <= '0;
    burst_left = 0;
    steady     = 1'b0;
    screens    = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: still, full swings each way, single steps
    send_packet(8'h00, 8'h00, 8'h00);
    send_packet(8'hFF, 8'h7F, 8'h80);
    send_packet(8'h80, 8'h80, 8'h7F);
    send_packet(8'h55, 8'h01, 8'hFF);
    send_packet(8'hAA, 8'hFF, 8'h01);

    // Shrink the screen under the cursor: erase uses the old spot
    set_screen(32'h0000_1000, 16, 8, 8'h00, 8'hFF);
    send_packet(8'h08, 8'h02, 8'hFE);

    // Zero-sized screen pins the cursor to the origin; base wraps
    set_screen(32'hFFFF_FFFF, 0, 0, 8'hFF, 8'h00);
    send_packet(8'h3C, 8'h7F, 8'h81);

    // Random packets over a range of screen settings
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      random_screen();
      steady = ($urandom_range(0, 3) == 0);
      for (i = 0; i < PHASE_PKTS; i++) begin
        send_packet(BYTE_W'($urandom_range(0, 255)), pick_delta(), pick_delta());
        if ($urandom_range(0, 40) == 0)
          hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (TAIL) @(posedge clk);
    if (board.pending.size() != 0) begin
      $display("%0t ns: %0d writes never arrived, expected none left actual %0d",
               $time, board.pending.size(), board.pending.size());
      board.mismatches += board.pending.size();
    end
    $display("Sent %0d bytes as %0d packets over %0d screen settings",
             board.bytes_taken, board.packets, screens);
    $display("Checked %0d pixel writes, %0d mismatches",
             board.writes_checked, board.mismatches);
    if (board.mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
